### sv/ttpe_pkg.sv
`default_nettype none
package ttpe_pkg;

    localparam int ADDR_BITS_DEF        = 12;
    localparam int ARG_SLOTS_DEF        = 32;
    localparam int MAX_ACCESS_BYTES_DEF = 16;

    localparam int TAG_W    = 56;
    localparam int ID_W     = 48;
    localparam int SEL_W    = 7;
    localparam int FUNC_W   = 4;
    localparam int SLOT_W   = 5;
    localparam int SIZE_W   = 3;
    localparam int ADDR_MAX = 24;
    localparam int NB_W     = 5;

    localparam logic [FUNC_W-1:0] FUNC_BINARY = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_SELECT = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_STORE  = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_FILL   = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_MOVE   = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_ARGST  = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_ARGLD  = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_RETST  = 4'd8;
    localparam logic [FUNC_W-1:0] FUNC_RETLD  = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_CONST  = 4'd10;

    typedef enum logic [3:0] {
        OP_BINARY, OP_SELECT, OP_LOAD, OP_STORE, OP_FILL, OP_MOVE,
        OP_ARGST, OP_ARGLD, OP_RETST, OP_RETLD, OP_CONST, OP_NOP
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [TAG_W-1:0]    tag_a;
        logic [TAG_W-1:0]    tag_b;
        logic                cond;
        logic [ADDR_MAX-1:0] addr;
        logic [ADDR_MAX-1:0] src;
        logic [NB_W-1:0]     nbytes;
        logic [ADDR_MAX:0]   len;
        logic [SLOT_W:0]     slot;
    } t_item;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_LOAD, ST_LOAD_END, ST_LOAD_FIN,
        ST_STORE, ST_FILL, ST_MV_RD, ST_MV_RD_END, ST_MV_WR, ST_MV_WR_END
    } t_state;

endpackage
`default_nettype wire

### sv/taint_tag_propagation_engine_top.sv
`default_nettype none
// Shadow-tag engine for information flow tracking. After reset all 2^ADDR_BITS entries of the
// shadow store are swept to zero, one byte a cycle, with full held high. Tag and slot
// operations then finish in the dispatch state; a load reads n bytes, a tainted store writes
// n bytes, a fill writes length bytes and a move reads length bytes and writes them out. The
// shadow store moves one byte per cycle, and a move is staged through a copy buffer. A two-entry
// queue on each side lets new transactions arrive and results wait while the engine works.
module taint_tag_propagation_engine_top #(
    parameter int ADDR_BITS        = ttpe_pkg::ADDR_BITS_DEF,
    parameter int ARG_SLOTS        = ttpe_pkg::ARG_SLOTS_DEF,
    parameter int MAX_ACCESS_BYTES = ttpe_pkg::MAX_ACCESS_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [ttpe_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [ttpe_pkg::TAG_W-1:0]    i_tag_a,
    input  wire logic [ttpe_pkg::TAG_W-1:0]    i_tag_b,
    input  wire logic                          i_cond,
    input  wire logic [ADDR_BITS-1:0]          i_address,
    input  wire logic [ADDR_BITS-1:0]          i_src_address,
    input  wire logic [ttpe_pkg::SIZE_W-1:0]   i_size_code,
    input  wire logic [ADDR_BITS:0]            i_length,
    input  wire logic [ttpe_pkg::SLOT_W-1:0]   i_slot,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [ttpe_pkg::TAG_W-1:0]         o_tag_out
);

    ttpe_pkg::t_back_ctl ctl;
    ttpe_pkg::t_item     item;
    logic                item_valid;

    ttpe_front #(
        .ADDR_BITS        (ADDR_BITS),
        .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_func        (i_func),
        .i_tag_a       (i_tag_a),
        .i_tag_b       (i_tag_b),
        .i_cond        (i_cond),
        .i_address     (i_address),
        .i_src_address (i_src_address),
        .i_size_code   (i_size_code),
        .i_length      (i_length),
        .i_slot        (i_slot),
        .i_ctl         (ctl),
        .o_valid       (item_valid),
        .o_item        (item)
    );

    ttpe_back #(
        .ADDR_BITS (ADDR_BITS),
        .ARG_SLOTS (ARG_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (item_valid),
        .i_item    (item),
        .o_ctl     (ctl),
        .empty     (empty),
        .pop       (pop),
        .o_tag_out (o_tag_out)
    );

endmodule
`default_nettype wire

### sv/ttpe_front.sv
`default_nettype none
module ttpe_front #(
    parameter int ADDR_BITS        = ttpe_pkg::ADDR_BITS_DEF,
    parameter int MAX_ACCESS_BYTES = ttpe_pkg::MAX_ACCESS_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [ttpe_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [ttpe_pkg::TAG_W-1:0]    i_tag_a,
    input  wire logic [ttpe_pkg::TAG_W-1:0]    i_tag_b,
    input  wire logic                          i_cond,
    input  wire logic [ADDR_BITS-1:0]          i_address,
    input  wire logic [ADDR_BITS-1:0]          i_src_address,
    input  wire logic [ttpe_pkg::SIZE_W-1:0]   i_size_code,
    input  wire logic [ADDR_BITS:0]            i_length,
    input  wire logic [ttpe_pkg::SLOT_W-1:0]   i_slot,
    input  wire ttpe_pkg::t_back_ctl           i_ctl,
    output logic                               o_valid,
    output ttpe_pkg::t_item                    o_item
);

    localparam logic [ADDR_BITS:0] DEPTH_V = {1'b1, {ADDR_BITS{1'b0}}};
    localparam logic [ttpe_pkg::NB_W-1:0] MAXB = ttpe_pkg::NB_W'(MAX_ACCESS_BYTES);

    ttpe_pkg::t_item          dec;
    logic [ttpe_pkg::NB_W-1:0] nb_raw;
    ttpe_pkg::t_item          r_q [2];
    logic                     r_wp;
    logic                     r_rp;
    logic [1:0]               r_cnt;
    logic                     take;
    logic                     give;

    always_comb begin
        dec        = '0;
        dec.tag_a  = i_tag_a;
        dec.tag_b  = i_tag_b;
        dec.cond   = i_cond;
        dec.addr   = ttpe_pkg::ADDR_MAX'(i_address);
        dec.src    = ttpe_pkg::ADDR_MAX'(i_src_address);
        dec.slot   = {1'b0, i_slot};
        nb_raw     = ttpe_pkg::NB_W'(1) << i_size_code;
        if (i_size_code > 3'd4 || nb_raw > MAXB) begin
            dec.nbytes = MAXB;
        end else begin
            dec.nbytes = nb_raw;
        end
        if (i_length > DEPTH_V) begin
            dec.len = (ttpe_pkg::ADDR_MAX + 1)'(DEPTH_V);
        end else begin
            dec.len = (ttpe_pkg::ADDR_MAX + 1)'(i_length);
        end
        unique case (i_func)
            ttpe_pkg::FUNC_BINARY: dec.op = ttpe_pkg::OP_BINARY;
            ttpe_pkg::FUNC_SELECT: dec.op = ttpe_pkg::OP_SELECT;
            ttpe_pkg::FUNC_LOAD:   dec.op = ttpe_pkg::OP_LOAD;
            ttpe_pkg::FUNC_STORE:  dec.op = ttpe_pkg::OP_STORE;
            ttpe_pkg::FUNC_FILL:   dec.op = ttpe_pkg::OP_FILL;
            ttpe_pkg::FUNC_MOVE:   dec.op = ttpe_pkg::OP_MOVE;
            ttpe_pkg::FUNC_ARGST:  dec.op = ttpe_pkg::OP_ARGST;
            ttpe_pkg::FUNC_ARGLD:  dec.op = ttpe_pkg::OP_ARGLD;
            ttpe_pkg::FUNC_RETST:  dec.op = ttpe_pkg::OP_RETST;
            ttpe_pkg::FUNC_RETLD:  dec.op = ttpe_pkg::OP_RETLD;
            ttpe_pkg::FUNC_CONST:  dec.op = ttpe_pkg::OP_CONST;
            default:               dec.op = ttpe_pkg::OP_NOP;
        endcase
    end

    assign full    = (r_cnt == 2'd2) || i_ctl.clearing;
    assign take    = push && !full;
    assign o_valid = (r_cnt != 2'd0);
    assign give    = i_ctl.pop && o_valid;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (take) begin
                r_wp <= ~r_wp;
            end
            if (give) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, take} - {1'b0, give};
        end
    end

endmodule
`default_nettype wire

### sv/ttpe_back.sv
`default_nettype none
module ttpe_back #(
    parameter int ADDR_BITS = ttpe_pkg::ADDR_BITS_DEF,
    parameter int ARG_SLOTS = ttpe_pkg::ARG_SLOTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire ttpe_pkg::t_item            i_item,
    output ttpe_pkg::t_back_ctl             o_ctl,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [ttpe_pkg::TAG_W-1:0]      o_tag_out
);

    localparam int DEPTH = 1 << ADDR_BITS;
    localparam int SIW   = (ARG_SLOTS > 1) ? $clog2(ARG_SLOTS) : 1;
    localparam int TW    = ttpe_pkg::TAG_W;
    localparam int IW    = ttpe_pkg::ID_W;

    ttpe_pkg::t_state   r_state, n_state;
    ttpe_pkg::t_item    r_item;
    logic [ADDR_BITS:0] r_cnt, n_cnt;
    logic [ADDR_BITS:0] cnt_inc, lim;
    logic               last;
    logic               r_pend, n_pend;
    logic [ADDR_BITS-1:0] r_pidx;
    logic               r_any, r_same;
    logic [IW-1:0]      r_first;
    logic [IW-1:0]      r_idc;
    logic [TW-1:0]      r_args [ARG_SLOTS];
    logic [TW-1:0]      r_ret;
    logic [TW-1:0]      r_shadow [DEPTH];
    logic [TW-1:0]      r_buf [DEPTH];
    logic [TW-1:0]      r_sh_rd, r_bf_rd;
    logic [TW-1:0]      r_oq [2];
    logic               r_owp, r_orp;
    logic [1:0]         r_ocnt;

    logic [ADDR_BITS-1:0] a_addr, s_addr, idx;
    logic [SIW-1:0]     slot_idx;
    logic               slot_ok;
    logic               start;
    logic               sh_we, bf_we;
    logic [ADDR_BITS-1:0] sh_wa, sh_ra, bf_wa, bf_ra;
    logic [TW-1:0]      sh_wd;
    logic               res_push, id_take, arg_we, arg_clr, ret_we, ret_clr, ld_init;
    logic [TW-1:0]      res_val;
    logic               opop;

    assign a_addr   = r_item.addr[ADDR_BITS-1:0];
    assign s_addr   = r_item.src[ADDR_BITS-1:0];
    assign idx      = r_cnt[ADDR_BITS-1:0];
    assign cnt_inc  = r_cnt + 1'b1;
    assign slot_idx = r_item.slot[SIW-1:0];
    assign slot_ok  = {1'b0, r_item.slot} < 7'(ARG_SLOTS);
    assign start    = (r_state == ttpe_pkg::ST_IDLE) && i_valid && (r_ocnt != 2'd2);

    always_comb begin
        if (r_item.op == ttpe_pkg::OP_LOAD || r_item.op == ttpe_pkg::OP_STORE) begin
            lim = (ADDR_BITS + 1)'(r_item.nbytes);
        end else begin
            lim = r_item.len[ADDR_BITS:0];
        end
        if (r_state == ttpe_pkg::ST_CLEAR) begin
            last = (idx == {ADDR_BITS{1'b1}});
        end else begin
            last = (cnt_inc == lim);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttpe_pkg::ST_CLEAR: begin
                if (last) begin
                    n_state = ttpe_pkg::ST_IDLE;
                end
            end
            ttpe_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = ttpe_pkg::ST_DISPATCH;
                end
            end
            ttpe_pkg::ST_DISPATCH: begin
                n_state = ttpe_pkg::ST_IDLE;
                case (r_item.op)
                    ttpe_pkg::OP_LOAD: n_state = ttpe_pkg::ST_LOAD;
                    ttpe_pkg::OP_STORE: begin
                        if (r_item.tag_a[0]) begin
                            n_state = ttpe_pkg::ST_STORE;
                        end
                    end
                    ttpe_pkg::OP_FILL: begin
                        if (r_item.len != '0) begin
                            n_state = ttpe_pkg::ST_FILL;
                        end
                    end
                    ttpe_pkg::OP_MOVE: begin
                        if (r_item.len != '0) begin
                            n_state = ttpe_pkg::ST_MV_RD;
                        end
                    end
                    default: n_state = ttpe_pkg::ST_IDLE;
                endcase
            end
            ttpe_pkg::ST_LOAD: begin
                if (last) begin
                    n_state = ttpe_pkg::ST_LOAD_END;
                end
            end
            ttpe_pkg::ST_LOAD_END: n_state = ttpe_pkg::ST_LOAD_FIN;
            ttpe_pkg::ST_LOAD_FIN: n_state = ttpe_pkg::ST_IDLE;
            ttpe_pkg::ST_STORE, ttpe_pkg::ST_FILL: begin
                if (last) begin
                    n_state = ttpe_pkg::ST_IDLE;
                end
            end
            ttpe_pkg::ST_MV_RD: begin
                if (last) begin
                    n_state = ttpe_pkg::ST_MV_RD_END;
                end
            end
            ttpe_pkg::ST_MV_RD_END: n_state = ttpe_pkg::ST_MV_WR;
            ttpe_pkg::ST_MV_WR: begin
                if (last) begin
                    n_state = ttpe_pkg::ST_MV_WR_END;
                end
            end
            ttpe_pkg::ST_MV_WR_END: n_state = ttpe_pkg::ST_IDLE;
            default: n_state = ttpe_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        n_cnt    = '0;
        n_pend   = 1'b0;
        sh_we    = 1'b0;
        sh_wa    = a_addr + idx;
        sh_wd    = '0;
        sh_ra    = a_addr + idx;
        bf_we    = 1'b0;
        bf_wa    = r_pidx;
        bf_ra    = idx;
        res_push = 1'b0;
        res_val  = '0;
        id_take  = 1'b0;
        arg_we   = 1'b0;
        arg_clr  = 1'b0;
        ret_we   = 1'b0;
        ret_clr  = 1'b0;
        ld_init  = 1'b0;
        unique case (r_state)
            ttpe_pkg::ST_CLEAR: begin
                sh_we = 1'b1;
                sh_wa = idx;
                n_cnt = last ? '0 : cnt_inc;
            end
            ttpe_pkg::ST_IDLE: begin
            end
            ttpe_pkg::ST_DISPATCH: begin
                ld_init = 1'b1;
                case (r_item.op)
                    ttpe_pkg::OP_BINARY: begin
                        res_push = 1'b1;
                        if (r_item.tag_a[0] || r_item.tag_b[0]) begin
                            res_val = {r_idc, 7'd0, 1'b1};
                            id_take = 1'b1;
                        end
                    end
                    ttpe_pkg::OP_SELECT: begin
                        res_push = 1'b1;
                        res_val  = r_item.cond ? r_item.tag_a : r_item.tag_b;
                    end
                    ttpe_pkg::OP_LOAD: begin
                    end
                    ttpe_pkg::OP_STORE: res_push = !r_item.tag_a[0];
                    ttpe_pkg::OP_FILL, ttpe_pkg::OP_MOVE: begin
                        res_push = (r_item.len == '0);
                    end
                    ttpe_pkg::OP_ARGST: begin
                        res_push = 1'b1;
                        arg_we   = slot_ok;
                    end
                    ttpe_pkg::OP_ARGLD: begin
                        res_push = 1'b1;
                        arg_clr  = slot_ok;
                        res_val  = slot_ok ? r_args[slot_idx] : '0;
                    end
                    ttpe_pkg::OP_RETST: begin
                        res_push = 1'b1;
                        ret_we   = 1'b1;
                    end
                    ttpe_pkg::OP_RETLD: begin
                        res_push = 1'b1;
                        ret_clr  = 1'b1;
                        res_val  = r_ret;
                    end
                    ttpe_pkg::OP_CONST: begin
                        res_push = 1'b1;
                        res_val  = {r_idc, 8'd0};
                        id_take  = 1'b1;
                    end
                    default: res_push = 1'b1;
                endcase
            end
            ttpe_pkg::ST_LOAD: begin
                n_pend = 1'b1;
                n_cnt  = last ? '0 : cnt_inc;
            end
            ttpe_pkg::ST_LOAD_END: begin
            end
            ttpe_pkg::ST_LOAD_FIN: begin
                res_push = 1'b1;
                if (r_any) begin
                    res_val = r_same ? {r_first, 7'd0, 1'b1} : {r_idc, 7'd0, 1'b1};
                    id_take = !r_same;
                end
            end
            ttpe_pkg::ST_STORE: begin
                sh_we    = 1'b1;
                sh_wd    = {r_item.tag_a[TW-1:8], 3'd0, r_cnt[3:0], r_item.tag_a[0]};
                n_cnt    = last ? '0 : cnt_inc;
                res_push = last;
            end
            ttpe_pkg::ST_FILL: begin
                sh_we    = 1'b1;
                sh_wd    = {r_item.tag_a[TW-1:8], 7'd0, r_item.tag_a[0]};
                n_cnt    = last ? '0 : cnt_inc;
                res_push = last;
            end
            ttpe_pkg::ST_MV_RD, ttpe_pkg::ST_MV_RD_END: begin
                sh_ra = s_addr + idx;
                bf_we = r_pend;
                if (r_state == ttpe_pkg::ST_MV_RD) begin
                    n_pend = 1'b1;
                    n_cnt  = last ? '0 : cnt_inc;
                end
            end
            ttpe_pkg::ST_MV_WR, ttpe_pkg::ST_MV_WR_END: begin
                sh_we = r_pend;
                sh_wa = a_addr + r_pidx;
                sh_wd = r_bf_rd;
                if (r_state == ttpe_pkg::ST_MV_WR) begin
                    n_pend = 1'b1;
                    n_cnt  = last ? '0 : cnt_inc;
                end else begin
                    res_push = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            r_shadow[sh_wa] <= sh_wd;
        end
        r_sh_rd <= r_shadow[sh_ra];
        if (bf_we) begin
            r_buf[bf_wa] <= r_sh_rd;
        end
        r_bf_rd <= r_buf[bf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_item <= i_item;
        end
        r_pidx <= idx;
        if (ld_init) begin
            r_any  <= 1'b0;
            r_same <= 1'b1;
        end else if (r_pend) begin
            r_any <= r_any | r_sh_rd[0];
            if (r_pidx == '0) begin
                r_first <= r_sh_rd[TW-1:8];
            end else if (r_sh_rd[TW-1:8] != r_first) begin
                r_same <= 1'b0;
            end
            if (r_sh_rd[7:1] != {3'd0, r_pidx[3:0]}) begin
                r_same <= 1'b0;
            end
        end
        if (res_push) begin
            r_oq[r_owp] <= res_val;
        end
        if (!i_rst_n) begin
            r_state <= ttpe_pkg::ST_CLEAR;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_idc   <= '0;
            r_ret   <= '0;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= 2'd0;
            for (int k = 0; k < ARG_SLOTS; k++) begin
                r_args[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            if (id_take) begin
                r_idc <= r_idc + 1'b1;
            end
            if (ret_we) begin
                r_ret <= r_item.tag_a;
            end else if (ret_clr) begin
                r_ret <= '0;
            end
            if (arg_we) begin
                r_args[slot_idx] <= r_item.tag_a;
            end else if (arg_clr) begin
                r_args[slot_idx] <= '0;
            end
            if (res_push) begin
                r_owp <= ~r_owp;
            end
            if (opop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, res_push} - {1'b0, opop};
        end
    end

    assign empty          = (r_ocnt == 2'd0);
    assign opop           = pop && !empty;
    assign o_tag_out      = r_oq[r_orp];
    assign o_ctl.pop      = start;
    assign o_ctl.clearing = (r_state == ttpe_pkg::ST_CLEAR);

endmodule
`default_nettype wire

### sv/ttpe_checker.sv
`default_nettype none
module ttpe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [55:0] o_tag_out
);

    // Reset drops any waiting result.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // The clearing sweep starts right after reset and blocks new transactions.
    a_reset_full: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("input accepted during clearing sweep");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_tag_out)))
        else $error("waiting result changed before it was taken");

endmodule

bind taint_tag_propagation_engine_top ttpe_checker u_ttpe_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .o_tag_out (o_tag_out)
);
`default_nettype wire
